// ===== hdl/gvl_pkg.sv =====
// Shared types and constants for the gamepad to velocity limiter.
package gvl_pkg;

    // Component and arithmetic widths
    localparam int COMP_W   = 17;   // signed vector component before limiting
    localparam int MAG_W    = 16;   // magnitude of one component
    localparam int OUT_W    = 16;   // result component
    localparam int MAX_W    = 15;   // configured maximum magnitude
    localparam int AXIS_W   = 16;   // gamepad axis
    localparam int ACC_W    = 32;   // product and sum of squares
    localparam int ROOT_W   = 16;   // floor square root
    localparam int SREM_W   = 17;   // square root partial remainder
    localparam int QUO_W    = 15;   // quotient of the scaling divide
    localparam int NCOMP    = 3;
    localparam int NBTN     = 4;
    localparam int CNT_W    = 4;

    localparam int SQRT_STEPS = 16;
    localparam int DIV_STEPS  = 15;
    localparam int SQ_LAST    = 4;  // three multiplies, three accumulates, then root setup

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_LINEAR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ANGULAR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RT_REST      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LT_REST      = 2'd3;

    localparam logic [MAX_W-1:0]  MAX_LINEAR_RST  = 15'd4096;
    localparam logic [MAX_W-1:0]  MAX_ANGULAR_RST = 15'd8192;
    localparam logic [AXIS_W-1:0] TRIGGER_REST_RST = 16'd16384;

    // Roll from the bumpers, one unit in Q1.14
    localparam logic [COMP_W-1:0] ROLL_POS = 17'd16384;
    localparam logic [COMP_W-1:0] ROLL_NEG = 17'h1C000;

    // Button bit positions
    localparam int BTN_A = 0;
    localparam int BTN_B = 1;
    localparam int BTN_X = 2;
    localparam int BTN_Y = 3;

    typedef struct packed {
        logic             load;
        logic             mul_en;
        logic             sq_mode;
        logic             acc_en;
        logic [1:0]       sel;
        logic             sqrt_init;
        logic             sqrt_step;
        logic             div_init;
        logic             div_step;
        logic             store;
        logic             publish;
    } gvl_cmd_t;

    typedef struct packed {
        logic can_publish;
    } gvl_status_t;

endpackage

// ===== hdl/gamepad_to_velocity_limiter_unit.sv =====
// Gamepad to velocity limiter top level: sequencer plus datapath.
// Each accepted gamepad sample yields exactly one result. A new sample is taken
// only once that result has gone into the output register, so one sample at a time.
// The two vector lanes run side by side: each does three squarings on a shared
// multiplier, a 16-step floor square root, and for each of its three components a
// multiply and a 15-step restoring divide, every step regardless of whether scaling
// applies. The result sits in an output register, so the next sample is taken while
// it waits; a finished sample waits until that register is free.
// Configuration writes take effect at the clock edge of the write.
module gamepad_to_velocity_limiter_unit (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_wr_en,
    input  logic [gvl_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gvl_pkg::CFG_DATA_W-1:0]      cfg_data,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [gvl_pkg::AXIS_W-1:0]   s_right_stick_x,
    input  logic signed [gvl_pkg::AXIS_W-1:0]   s_right_stick_y,
    input  logic signed [gvl_pkg::AXIS_W-1:0]   s_left_stick_x,
    input  logic signed [gvl_pkg::AXIS_W-1:0]   s_left_stick_y,
    input  logic signed [gvl_pkg::AXIS_W-1:0]   s_right_trigger,
    input  logic signed [gvl_pkg::AXIS_W-1:0]   s_left_trigger,
    input  logic                                s_right_bumper,
    input  logic                                s_left_bumper,
    input  logic                                s_button_a,
    input  logic                                s_button_b,
    input  logic                                s_button_x,
    input  logic                                s_button_y,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [gvl_pkg::OUT_W-1:0]    m_lin_x,
    output logic signed [gvl_pkg::OUT_W-1:0]    m_lin_y,
    output logic signed [gvl_pkg::OUT_W-1:0]    m_lin_z,
    output logic signed [gvl_pkg::OUT_W-1:0]    m_ang_x,
    output logic signed [gvl_pkg::OUT_W-1:0]    m_ang_y,
    output logic signed [gvl_pkg::OUT_W-1:0]    m_ang_z,
    output logic                                m_gripper_open,
    output logic                                m_gripper_request,
    output logic                                m_select_gripper_tcp,
    output logic                                m_select_wrist_link,
    output logic                                m_select_camera_tcp
);

    gvl_pkg::gvl_cmd_t    cmd;
    gvl_pkg::gvl_status_t status;

    gvl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    gvl_datapath u_dp (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cmd                  (cmd),
        .status               (status),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .s_right_stick_x      (s_right_stick_x),
        .s_right_stick_y      (s_right_stick_y),
        .s_left_stick_x       (s_left_stick_x),
        .s_left_stick_y       (s_left_stick_y),
        .s_right_trigger      (s_right_trigger),
        .s_left_trigger       (s_left_trigger),
        .s_right_bumper       (s_right_bumper),
        .s_left_bumper        (s_left_bumper),
        .s_button_a           (s_button_a),
        .s_button_b           (s_button_b),
        .s_button_x           (s_button_x),
        .s_button_y           (s_button_y),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_lin_x              (m_lin_x),
        .m_lin_y              (m_lin_y),
        .m_lin_z              (m_lin_z),
        .m_ang_x              (m_ang_x),
        .m_ang_y              (m_ang_y),
        .m_ang_z              (m_ang_z),
        .m_gripper_open       (m_gripper_open),
        .m_gripper_request    (m_gripper_request),
        .m_select_gripper_tcp (m_select_gripper_tcp),
        .m_select_wrist_link  (m_select_wrist_link),
        .m_select_camera_tcp  (m_select_camera_tcp)
    );

endmodule

// ===== hdl/gvl_lane.sv =====
// One velocity vector: sum of squares, floor square root and per-component scaling divide.
module gvl_lane (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  gvl_pkg::gvl_cmd_t                  cmd,
    input  logic signed [gvl_pkg::COMP_W-1:0]  comp_in [gvl_pkg::NCOMP],
    input  logic [gvl_pkg::MAX_W-1:0]          max_mag,
    output logic [gvl_pkg::OUT_W-1:0]          res     [gvl_pkg::NCOMP]
);

    logic [gvl_pkg::MAG_W-1:0]  mag_reg  [gvl_pkg::NCOMP];
    logic                       neg_reg  [gvl_pkg::NCOMP];
    logic [gvl_pkg::OUT_W-1:0]  orig_reg [gvl_pkg::NCOMP];
    logic [gvl_pkg::OUT_W-1:0]  res_reg  [gvl_pkg::NCOMP];
    logic [gvl_pkg::MAG_W-1:0]  mag_next [gvl_pkg::NCOMP];
    logic [gvl_pkg::COMP_W-1:0] abs_val  [gvl_pkg::NCOMP];

    logic [gvl_pkg::ACC_W-1:0]  prod_reg, prod_next;
    logic [gvl_pkg::ACC_W-1:0]  acc_reg, acc_next;
    logic [gvl_pkg::ACC_W-1:0]  rad_reg, rad_next;
    logic [gvl_pkg::SREM_W-1:0] srem_reg, srem_next;
    logic [gvl_pkg::ROOT_W-1:0] root_reg, root_next;
    logic [gvl_pkg::ROOT_W-1:0] drem_reg, drem_next;
    logic [gvl_pkg::QUO_W-1:0]  dq_reg, dq_next;

    logic [gvl_pkg::MAG_W-1:0]  sel_mag;
    logic                       sel_neg;
    logic [gvl_pkg::OUT_W-1:0]  sel_orig;
    logic [gvl_pkg::MAG_W-1:0]  mul_b;

    logic [gvl_pkg::SREM_W+1:0] s_rem_t, s_trial, s_diff;
    logic                       s_ge;
    logic [gvl_pkg::ROOT_W:0]   d_t, d_div, d_diff;
    logic                       d_ge;
    logic                       scale;
    logic [gvl_pkg::OUT_W-1:0]  q_val, store_val;

    always_comb begin
        for (int i = 0; i < gvl_pkg::NCOMP; i++) begin
            abs_val[i]  = comp_in[i][gvl_pkg::COMP_W-1] ?
                          (gvl_pkg::COMP_W'(0) - comp_in[i]) : comp_in[i];
            mag_next[i] = abs_val[i][gvl_pkg::MAG_W-1:0];
        end
    end

    always_comb begin
        unique case (cmd.sel)
            2'd1: begin
                sel_mag  = mag_reg[1];
                sel_neg  = neg_reg[1];
                sel_orig = orig_reg[1];
            end
            2'd2: begin
                sel_mag  = mag_reg[2];
                sel_neg  = neg_reg[2];
                sel_orig = orig_reg[2];
            end
            default: begin
                sel_mag  = mag_reg[0];
                sel_neg  = neg_reg[0];
                sel_orig = orig_reg[0];
            end
        endcase
    end

    // Shared multiplier: square for the norm, times max for scaling
    assign mul_b     = cmd.sq_mode ? sel_mag : {1'b0, max_mag};
    assign prod_next = gvl_pkg::ACC_W'(sel_mag) * gvl_pkg::ACC_W'(mul_b);
    assign acc_next  = acc_reg + prod_reg;

    // Restoring square root, two radicand bits per step
    assign s_rem_t   = {srem_reg, rad_reg[gvl_pkg::ACC_W-1 -: 2]};
    assign s_trial   = {1'b0, root_reg, 2'b01};
    assign s_diff    = s_rem_t - s_trial;
    assign s_ge      = s_rem_t >= s_trial;
    assign srem_next = s_ge ? s_diff[gvl_pkg::SREM_W-1:0] : s_rem_t[gvl_pkg::SREM_W-1:0];
    assign root_next = {root_reg[gvl_pkg::ROOT_W-2:0], s_ge};
    assign rad_next  = {rad_reg[gvl_pkg::ACC_W-3:0], 2'b00};

    // Restoring divide by the root; quotient is known to fit QUO_W bits when scaling
    assign d_div     = {1'b0, root_reg};
    assign d_t       = {drem_reg, dq_reg[gvl_pkg::QUO_W-1]};
    assign d_diff    = d_t - d_div;
    assign d_ge      = d_t >= d_div;
    assign drem_next = d_ge ? d_diff[gvl_pkg::ROOT_W-1:0] : d_t[gvl_pkg::ROOT_W-1:0];
    assign dq_next   = {dq_reg[gvl_pkg::QUO_W-2:0], d_ge};

    assign scale     = root_reg > {1'b0, max_mag};
    assign q_val     = {1'b0, dq_reg};
    assign store_val = !scale ? sel_orig :
                       (sel_neg ? (gvl_pkg::OUT_W'(0) - q_val) : q_val);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            for (int i = 0; i < gvl_pkg::NCOMP; i++) begin
                mag_reg[i]  <= mag_next[i];
                neg_reg[i]  <= comp_in[i][gvl_pkg::COMP_W-1];
                orig_reg[i] <= comp_in[i][gvl_pkg::OUT_W-1:0];
            end
        end
        if (cmd.mul_en) begin
            prod_reg <= prod_next;
        end
        if (cmd.load) begin
            acc_reg <= '0;
        end else if (cmd.acc_en) begin
            acc_reg <= acc_next;
        end
        if (cmd.sqrt_init) begin
            rad_reg  <= acc_reg;
            srem_reg <= '0;
            root_reg <= '0;
        end else if (cmd.sqrt_step) begin
            rad_reg  <= rad_next;
            srem_reg <= srem_next;
            root_reg <= root_next;
        end
        if (cmd.div_init) begin
            drem_reg <= prod_reg[gvl_pkg::ACC_W-2:gvl_pkg::QUO_W];
            dq_reg   <= prod_reg[gvl_pkg::QUO_W-1:0];
        end else if (cmd.div_step) begin
            drem_reg <= drem_next;
            dq_reg   <= dq_next;
        end
        for (int i = 0; i < gvl_pkg::NCOMP; i++) begin
            if (cmd.store && cmd.sel == 2'(i)) begin
                res_reg[i] <= store_val;
            end
        end
    end

    assign res = res_reg;

    // Partial remainder must start below the divisor or the quotient overflows
    a_div_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.div_init && scale) |-> (prod_reg[gvl_pkg::ACC_W-2:gvl_pkg::QUO_W] < root_reg))
        else $error("scaling divide starts with remainder not below root");

    a_q_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.store && scale) |-> (dq_reg <= max_mag))
        else $error("scaled component exceeds configured maximum");

endmodule

// ===== hdl/gvl_datapath.sv =====
// Datapath: config registers, input mapping, button edges, two vector lanes, output register.
module gvl_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  gvl_pkg::gvl_cmd_t                   cmd,
    output gvl_pkg::gvl_status_t                status,

    input  logic                                cfg_wr_en,
    input  logic [gvl_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gvl_pkg::CFG_DATA_W-1:0]      cfg_data,

    input  logic signed [gvl_pkg::AXIS_W-1:0]   s_right_stick_x,
    input  logic signed [gvl_pkg::AXIS_W-1:0]   s_right_stick_y,
    input  logic signed [gvl_pkg::AXIS_W-1:0]   s_left_stick_x,
    input  logic signed [gvl_pkg::AXIS_W-1:0]   s_left_stick_y,
    input  logic signed [gvl_pkg::AXIS_W-1:0]   s_right_trigger,
    input  logic signed [gvl_pkg::AXIS_W-1:0]   s_left_trigger,
    input  logic                                s_right_bumper,
    input  logic                                s_left_bumper,
    input  logic                                s_button_a,
    input  logic                                s_button_b,
    input  logic                                s_button_x,
    input  logic                                s_button_y,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [gvl_pkg::OUT_W-1:0]    m_lin_x,
    output logic signed [gvl_pkg::OUT_W-1:0]    m_lin_y,
    output logic signed [gvl_pkg::OUT_W-1:0]    m_lin_z,
    output logic signed [gvl_pkg::OUT_W-1:0]    m_ang_x,
    output logic signed [gvl_pkg::OUT_W-1:0]    m_ang_y,
    output logic signed [gvl_pkg::OUT_W-1:0]    m_ang_z,
    output logic                                m_gripper_open,
    output logic                                m_gripper_request,
    output logic                                m_select_gripper_tcp,
    output logic                                m_select_wrist_link,
    output logic                                m_select_camera_tcp
);

    logic [gvl_pkg::MAX_W-1:0]  max_lin_reg, max_ang_reg;
    logic [gvl_pkg::AXIS_W-1:0] rt_rest_reg, lt_rest_reg;

    logic [gvl_pkg::NBTN-1:0]   prev_btn_reg, btn_next, rise_next, rise_reg;
    logic                       grip_flag_reg, grip_flag_next;

    logic [gvl_pkg::AXIS_W:0]   d_lt, d_rt;
    logic [gvl_pkg::AXIS_W+1:0] d_sum, d_adj, d_half;
    logic [gvl_pkg::OUT_W-1:0]  lin_x_sat;

    logic signed [gvl_pkg::COMP_W-1:0] lin_comp [gvl_pkg::NCOMP];
    logic signed [gvl_pkg::COMP_W-1:0] ang_comp [gvl_pkg::NCOMP];
    logic [gvl_pkg::OUT_W-1:0]         lin_res  [gvl_pkg::NCOMP];
    logic [gvl_pkg::OUT_W-1:0]         ang_res  [gvl_pkg::NCOMP];

    logic                       m_valid_reg, m_valid_next;
    logic [gvl_pkg::OUT_W-1:0]  m_lin_reg [gvl_pkg::NCOMP];
    logic [gvl_pkg::OUT_W-1:0]  m_ang_reg [gvl_pkg::NCOMP];
    logic                       m_grip_reg;
    logic [gvl_pkg::NBTN-1:0]   m_rise_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_lin_reg <= gvl_pkg::MAX_LINEAR_RST;
            max_ang_reg <= gvl_pkg::MAX_ANGULAR_RST;
            rt_rest_reg <= gvl_pkg::TRIGGER_REST_RST;
            lt_rest_reg <= gvl_pkg::TRIGGER_REST_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                gvl_pkg::REG_MAX_LINEAR:  max_lin_reg <= cfg_data[gvl_pkg::MAX_W-1:0];
                gvl_pkg::REG_MAX_ANGULAR: max_ang_reg <= cfg_data[gvl_pkg::MAX_W-1:0];
                gvl_pkg::REG_RT_REST:     rt_rest_reg <= cfg_data;
                gvl_pkg::REG_LT_REST:     lt_rest_reg <= cfg_data;
            endcase
        end
    end

    // Forward speed from the triggers: halve toward zero, then saturate
    assign d_lt   = {s_left_trigger[gvl_pkg::AXIS_W-1], s_left_trigger}
                  - {lt_rest_reg[gvl_pkg::AXIS_W-1], lt_rest_reg};
    assign d_rt   = {s_right_trigger[gvl_pkg::AXIS_W-1], s_right_trigger}
                  - {rt_rest_reg[gvl_pkg::AXIS_W-1], rt_rest_reg};
    assign d_sum  = {d_lt[gvl_pkg::AXIS_W], d_lt} - {d_rt[gvl_pkg::AXIS_W], d_rt};
    assign d_adj  = d_sum + (gvl_pkg::AXIS_W+2)'(d_sum[gvl_pkg::AXIS_W+1]);
    assign d_half = {d_adj[gvl_pkg::AXIS_W+1], d_adj[gvl_pkg::AXIS_W+1:1]};

    always_comb begin
        if (d_half[gvl_pkg::AXIS_W+1:gvl_pkg::OUT_W-1] == '0
            || d_half[gvl_pkg::AXIS_W+1:gvl_pkg::OUT_W-1] == '1) begin
            lin_x_sat = d_half[gvl_pkg::OUT_W-1:0];
        end else if (d_half[gvl_pkg::AXIS_W+1]) begin
            lin_x_sat = {1'b1, {(gvl_pkg::OUT_W-1){1'b0}}};
        end else begin
            lin_x_sat = {1'b0, {(gvl_pkg::OUT_W-1){1'b1}}};
        end
    end

    always_comb begin
        lin_comp[0] = {lin_x_sat[gvl_pkg::OUT_W-1], lin_x_sat};
        lin_comp[1] = gvl_pkg::COMP_W'(0)
                    - {s_right_stick_x[gvl_pkg::AXIS_W-1], s_right_stick_x};
        lin_comp[2] = {s_right_stick_y[gvl_pkg::AXIS_W-1], s_right_stick_y};
        ang_comp[0] = {s_left_stick_x[gvl_pkg::AXIS_W-1], s_left_stick_x};
        ang_comp[1] = {s_left_stick_y[gvl_pkg::AXIS_W-1], s_left_stick_y};
        if (s_right_bumper && !s_left_bumper) begin
            ang_comp[2] = gvl_pkg::ROLL_POS;
        end else if (s_left_bumper && !s_right_bumper) begin
            ang_comp[2] = gvl_pkg::ROLL_NEG;
        end else begin
            ang_comp[2] = '0;
        end
    end

    assign btn_next       = {s_button_y, s_button_x, s_button_b, s_button_a};
    assign rise_next      = btn_next & ~prev_btn_reg;
    assign grip_flag_next = grip_flag_reg ^ rise_next[gvl_pkg::BTN_A];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_btn_reg  <= '0;
            grip_flag_reg <= 1'b0;
        end else if (cmd.load) begin
            prev_btn_reg  <= btn_next;
            grip_flag_reg <= grip_flag_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rise_reg <= rise_next;
        end
    end

    gvl_lane u_lin (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .comp_in (lin_comp),
        .max_mag (max_lin_reg),
        .res     (lin_res)
    );

    gvl_lane u_ang (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .comp_in (ang_comp),
        .max_mag (max_ang_reg),
        .res     (ang_res)
    );

    // Output register: the next sample can be worked on while this one waits
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.publish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.publish) begin
            m_lin_reg  <= lin_res;
            m_ang_reg  <= ang_res;
            m_grip_reg <= grip_flag_reg;
            m_rise_reg <= rise_reg;
        end
    end

    assign status.can_publish = !m_valid_reg || m_ready;

    assign m_valid              = m_valid_reg;
    assign m_lin_x              = m_lin_reg[0];
    assign m_lin_y              = m_lin_reg[1];
    assign m_lin_z              = m_lin_reg[2];
    assign m_ang_x              = m_ang_reg[0];
    assign m_ang_y              = m_ang_reg[1];
    assign m_ang_z              = m_ang_reg[2];
    assign m_gripper_open       = m_grip_reg;
    assign m_gripper_request    = m_rise_reg[gvl_pkg::BTN_A];
    assign m_select_gripper_tcp = m_rise_reg[gvl_pkg::BTN_B];
    assign m_select_wrist_link  = m_rise_reg[gvl_pkg::BTN_X];
    assign m_select_camera_tcp  = m_rise_reg[gvl_pkg::BTN_Y];

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.publish |-> (!m_valid_reg || m_ready))
        else $error("result overwritten before it was taken");

endmodule

// ===== hdl/gvl_ctrl.sv =====
// Sequencer for one sample: norm, square root, three scaling divides, publish.
module gvl_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  gvl_pkg::gvl_status_t status,
    output gvl_pkg::gvl_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SQ     = 3'd1;
    localparam logic [2:0] ST_SQRT   = 3'd2;
    localparam logic [2:0] ST_MUL    = 3'd3;
    localparam logic [2:0] ST_DINIT  = 3'd4;
    localparam logic [2:0] ST_DIV    = 3'd5;
    localparam logic [2:0] ST_STORE  = 3'd6;
    localparam logic [2:0] ST_FINISH = 3'd7;

    localparam logic [gvl_pkg::CNT_W-1:0] SQ_END   = gvl_pkg::CNT_W'(gvl_pkg::SQ_LAST);
    localparam logic [gvl_pkg::CNT_W-1:0] SQ_MULS  = gvl_pkg::CNT_W'(gvl_pkg::NCOMP);
    localparam logic [gvl_pkg::CNT_W-1:0] SQRT_END = gvl_pkg::CNT_W'(gvl_pkg::SQRT_STEPS - 1);
    localparam logic [gvl_pkg::CNT_W-1:0] DIV_END  = gvl_pkg::CNT_W'(gvl_pkg::DIV_STEPS - 1);
    localparam logic [1:0]                K_LAST   = 2'(gvl_pkg::NCOMP - 1);

    logic [2:0]                state_reg, state_next;
    logic [gvl_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]                k_reg, k_next;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        k_next     = k_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_SQ;
                end
            end
            ST_SQ: begin
                // multiply at counts 0..2, accumulate each product in the cycle after it
                cmd.sq_mode   = 1'b1;
                cmd.mul_en    = cnt_reg < SQ_MULS;
                cmd.sel       = (cnt_reg < SQ_MULS) ? cnt_reg[1:0] : 2'd0;
                cmd.acc_en    = (cnt_reg != '0) && (cnt_reg < SQ_END);
                cmd.sqrt_init = cnt_reg == SQ_END;
                if (cnt_reg == SQ_END) begin
                    cnt_next   = '0;
                    state_next = ST_SQRT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                if (cnt_reg == SQRT_END) begin
                    k_next     = '0;
                    state_next = ST_MUL;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_MUL: begin
                cmd.mul_en = 1'b1;
                cmd.sel    = k_reg;
                state_next = ST_DINIT;
            end
            ST_DINIT: begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == DIV_END) begin
                    state_next = ST_STORE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_STORE: begin
                cmd.store = 1'b1;
                cmd.sel   = k_reg;
                if (k_reg == K_LAST) begin
                    state_next = ST_FINISH;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_FINISH: begin
                if (status.can_publish) begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            k_reg     <= k_next;
        end
    end

    a_load_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (state_reg == ST_SQ && cnt_reg == '0))
        else $error("accepted transaction did not start the norm");

    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (cnt_reg <= DIV_END && k_reg <= K_LAST))
        else $error("divide counter or component index out of range");

    a_last_store: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_STORE && k_reg == K_LAST) |=> (state_reg == ST_FINISH))
        else $error("last component stored without finishing");

endmodule
